// ===== hw/rtl/lrut_pkg.sv =====
// lrut_pkg: shared types and constants for the LRU replacement tracker.
// Holds operation and status codes, FSM states and the control/status
// structs between lrut_ctrl and lrut_dp. No dependencies.
`default_nettype none

package lrut_pkg;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 16;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_VICTIM = 2'd1,
    FN_ERASE  = 2'd2
  } func_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;         // latch input word, restart read pointer
    logic    rd;           // issue list read at pointer, advance pointer
    logic    start_shift;  // hit: pointer to hit position + 1
    logic    shift_wr;     // move returned entry down one slot
    logic    wr_new;       // append key at tail, count + 1
    logic    wr_touch;     // write key into last slot, count unchanged
    logic    dec;          // count - 1
    logic    st_ld;        // capture status code
    status_t st_code;
    logic    out_load;     // load output word registers
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hit;      // returned entry matches (any entry for victim)
    logic              rd_more;  // pointer still below count
    logic              pv;       // read data valid this cycle
    logic              full;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrut_ctrl.sv =====
// lrut_ctrl: operation sequencer for the LRU tracker (scan, shift, respond)
// and the output valid register. Depends on lrut_pkg; drives lrut_dp
// through lrut_pkg::cmd_t and observes lrut_pkg::stat_t.
`default_nettype none

module lrut_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire lrut_pkg::stat_t stat,
  output lrut_pkg::cmd_t      cmd
);

  lrut_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrut_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.st_code   = lrut_pkg::ST_MISS;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      lrut_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = lrut_pkg::S_SCAN;
        end
      end
      lrut_pkg::S_SCAN: begin
        case (stat.func)
          lrut_pkg::FN_INSERT, lrut_pkg::FN_VICTIM, lrut_pkg::FN_ERASE: begin
            if (stat.hit) begin
              cmd.start_shift = 1'b1;
              state_nxt       = lrut_pkg::S_SHIFT;
            end else if (stat.rd_more) begin
              cmd.rd = 1'b1;
            end else if (!stat.pv) begin
              // list exhausted without a match
              cmd.st_ld = 1'b1;
              state_nxt = lrut_pkg::S_RESP;
              if (stat.func == lrut_pkg::FN_INSERT) begin
                if (stat.full) begin
                  cmd.st_code = lrut_pkg::ST_FULL;
                end else begin
                  cmd.wr_new  = 1'b1;
                  cmd.st_code = lrut_pkg::ST_OK;
                end
              end
            end
          end
          default: begin
            cmd.st_ld = 1'b1;
            state_nxt = lrut_pkg::S_RESP;
          end
        endcase
      end
      lrut_pkg::S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (stat.rd_more) begin
          cmd.rd = 1'b1;
        end else if (!stat.pv) begin
          // gap closed; a touched key goes back in at the tail
          if (stat.func == lrut_pkg::FN_INSERT) begin
            cmd.wr_touch = 1'b1;
          end else begin
            cmd.dec = 1'b1;
          end
          cmd.st_ld   = 1'b1;
          cmd.st_code = lrut_pkg::ST_OK;
          state_nxt   = lrut_pkg::S_RESP;
        end
      end
      lrut_pkg::S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = lrut_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lrut_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != lrut_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  // a pending output word is never overwritten
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten while stalled");

  // no result can appear the cycle right after an input is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid_r))
    else $error("result raised directly after accept");

  // a shift only starts from a returned read
  a_shift_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_shift |-> stat.pv)
    else $error("shift started without read data");

endmodule

`default_nettype wire

// ===== hw/rtl/lrut_dp.sv =====
// lrut_dp: datapath of the LRU tracker: ordered key list memory, read
// pointer, entry count, key compare and output word registers.
// Depends on lrut_pkg; commanded by lrut_ctrl.
`default_nettype none

module lrut_dp #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [lrut_pkg::FUNC_W-1:0]     in_func,
  input  wire logic [lrut_pkg::KEY_W-1:0]      in_key,
  input  wire lrut_pkg::cmd_t                  cmd,
  output lrut_pkg::stat_t                      stat,
  output logic [lrut_pkg::STAT_W-1:0]          out_status,
  output logic [lrut_pkg::KEY_W-1:0]           out_victim_key,
  output logic [lrut_pkg::CNT_W-1:0]           out_entry_count
);

  localparam int IW     = $clog2(ENTRIES);
  localparam int CW     = $clog2(ENTRIES + 1);
  localparam int KW_EXT = (KEY_BITS > lrut_pkg::KEY_W) ? KEY_BITS : lrut_pkg::KEY_W;
  localparam int CW_EXT = (CW > lrut_pkg::CNT_W) ? CW : lrut_pkg::CNT_W;

  // list memory: slot 0 least recent, slot count-1 most recent
  logic [KEY_BITS-1:0] mem [ENTRIES];

  logic [lrut_pkg::FUNC_W-1:0] func_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               ptr_r;
  logic                        pv_r;
  logic [IW-1:0]               pidx_r;
  logic [KEY_BITS-1:0]         rd_data_r;
  logic [lrut_pkg::KEY_W-1:0]  victim_r;
  lrut_pkg::status_t           status_r;

  logic [KW_EXT-1:0]   key_ext;
  logic [KW_EXT-1:0]   rd_ext;
  logic [CW_EXT-1:0]   cnt_ext;
  logic [CW-1:0]       cnt_m1;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  assign key_ext = KW_EXT'(in_key);
  assign rd_ext  = KW_EXT'(rd_data_r);
  assign cnt_ext = CW_EXT'(count_r);
  assign cnt_m1  = count_r - CW'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[IW-1:0];
    wr_data = key_r;
    if (cmd.shift_wr && pv_r) begin
      wr_en   = 1'b1;
      wr_addr = pidx_r - IW'(1);
      wr_data = rd_data_r;
    end else if (cmd.wr_new) begin
      wr_en = 1'b1;
    end else if (cmd.wr_touch) begin
      wr_en   = 1'b1;
      wr_addr = cnt_m1[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[ptr_r[IW-1:0]];
      pidx_r    <= ptr_r[IW-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      pv_r    <= 1'b0;
    end else begin
      pv_r <= cmd.rd;
      if (cmd.load) begin
        ptr_r <= '0;
      end else if (cmd.start_shift) begin
        ptr_r <= CW'(pidx_r) + CW'(1);
      end else if (cmd.rd) begin
        ptr_r <= ptr_r + CW'(1);
      end
      if (cmd.wr_new) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.dec) begin
        count_r <= cnt_m1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      key_r    <= key_ext[KEY_BITS-1:0];
      victim_r <= '0;
    end else if (cmd.start_shift && func_r == lrut_pkg::FN_VICTIM) begin
      victim_r <= rd_ext[lrut_pkg::KEY_W-1:0];
    end
    if (cmd.st_ld) begin
      status_r <= cmd.st_code;
    end
    if (cmd.out_load) begin
      out_status      <= status_r;
      out_victim_key  <= victim_r;
      out_entry_count <= cnt_ext[lrut_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    stat.func    = func_r;
    stat.pv      = pv_r;
    stat.hit     = pv_r && (func_r == lrut_pkg::FN_VICTIM || rd_data_r == key_r);
    stat.rd_more = (ptr_r < count_r);
    stat.full    = (count_r == CW'(ENTRIES));
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above capacity");

  // shifted entries always land inside the live list
  a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift_wr && pv_r) |-> (CW'(pidx_r) < count_r && pidx_r != '0))
    else $error("shift write outside live entries");

endmodule

`default_nettype wire

// ===== hw/rtl/lru_replacement_tracker.sv =====
// lru_replacement_tracker: exact LRU order tracker over up to ENTRIES keys.
// Input channel in_valid/in_stall carries a word {in_func, in_key}:
//   insert/touch moves or appends the key at the most-recent end,
//   victim pops the least-recent key, erase removes the given key.
// Output channel out_valid/out_stall returns one word per input:
//   out_status (ok / empty or not found / full), out_victim_key, out_entry_count.
// One operation is in flight at a time. The list sits in a memory with one
// read and one write port and is walked one entry per cycle: a scan to find
// the key, then a shift to close the gap, then a respond step that loads the
// output register and returns to idle. A new word is taken only in idle,
// so one operation must finish before the next word is accepted.
// The next word is accepted once the previous result sits in the output
// register, even while the receiver stalls it; if a new result is ready
// while the old one is still stalled, the tracker holds in its respond step.
// Synchronous active-low reset empties the list (count zero); the list
// memory itself is not cleared and needs no clearing pass.
// Depends on lrut_pkg, lrut_ctrl, lrut_dp.
`default_nettype none

module lru_replacement_tracker #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [lrut_pkg::FUNC_W-1:0]  in_func,
  input  wire logic [lrut_pkg::KEY_W-1:0]   in_key,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [lrut_pkg::STAT_W-1:0]       out_status,
  output logic [lrut_pkg::KEY_W-1:0]        out_victim_key,
  output logic [lrut_pkg::CNT_W-1:0]        out_entry_count
);

  lrut_pkg::cmd_t  cmd;
  lrut_pkg::stat_t stat;

  lrut_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrut_dp #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_func         (in_func),
    .in_key          (in_key),
    .cmd             (cmd),
    .stat            (stat),
    .out_status      (out_status),
    .out_victim_key  (out_victim_key),
    .out_entry_count (out_entry_count)
  );

endmodule

`default_nettype wire

// ===== dv/lru_replacement_tracker_checker.sv =====
// Checker for lru_replacement_tracker: watches both channels, keeps its own
// recency list, predicts every result word and compares it field by field.
// Depends on lrut_pkg for field widths and operation/status codes.
`timescale 1ns / 100ps

module lru_replacement_tracker_checker #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [lrut_pkg::FUNC_W-1:0]   in_func,
  input  logic [lrut_pkg::KEY_W-1:0]    in_key,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [lrut_pkg::STAT_W-1:0]   out_status,
  input  logic [lrut_pkg::KEY_W-1:0]    out_victim_key,
  input  logic [lrut_pkg::CNT_W-1:0]    out_entry_count,
  output int                            mismatch_count,
  output int                            results_owed
);

  localparam int FUNC_W = lrut_pkg::FUNC_W;
  localparam int KEY_W  = lrut_pkg::KEY_W;
  localparam int CNT_W  = lrut_pkg::CNT_W;

  typedef struct {
    lrut_pkg::status_t   status;
    logic [KEY_W-1:0]    victim_key;
    logic [CNT_W-1:0]    entry_count;
  } lru_result_t;

  // index 0 is the least recently used key
  logic [KEY_BITS-1:0] recency[$];
  lru_result_t         owed_results[$];
  int                  fail_tally = 0;
  int                  owed_count = 0;

  assign mismatch_count = fail_tally;
  assign results_owed   = owed_count;

  function automatic lru_result_t apply_lru_op(input logic [FUNC_W-1:0] func,
                                               input logic [KEY_W-1:0]  key);
    lru_result_t         r;
    logic [KEY_BITS-1:0] k;
    int                  pos;
    k = key[KEY_BITS-1:0];
    r.status = lrut_pkg::ST_MISS;
    r.victim_key = '0;
    pos = -1;
    foreach (recency[i]) begin
      if (pos < 0 && recency[i] == k) pos = i;
    end
    case (func)
      lrut_pkg::FN_INSERT: begin
        if (pos >= 0) begin
          // touch: move to the most-recent end, works even when full
          recency.delete(pos);
          recency.push_back(k);
          r.status = lrut_pkg::ST_OK;
        end else if (recency.size() >= ENTRIES) begin
          r.status = lrut_pkg::ST_FULL;
        end else begin
          recency.push_back(k);
          r.status = lrut_pkg::ST_OK;
        end
      end
      lrut_pkg::FN_VICTIM: begin
        if (recency.size() > 0) begin
          r.victim_key = KEY_W'(recency.pop_front());
          r.status = lrut_pkg::ST_OK;
        end
      end
      lrut_pkg::FN_ERASE: begin
        if (pos >= 0) begin
          recency.delete(pos);
          r.status = lrut_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(recency.size());
    return r;
  endfunction

  always @(posedge clk) begin
    lru_result_t want;
    if (!rst_n) begin
      recency.delete();
      owed_results.delete();
    end else begin
      // a result word always belongs to an earlier input word, so pop first
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result word: status %0d victim_key %h entry_count %0d",
                 out_status, out_victim_key, out_entry_count);
          fail_tally++;
        end else begin
          want = owed_results.pop_front();
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_status);
            fail_tally++;
          end
          if (out_victim_key !== want.victim_key) begin
            $error("victim_key mismatch: expected %h, got %h",
                   want.victim_key, out_victim_key);
            fail_tally++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count mismatch: expected %0d, got %0d",
                   want.entry_count, out_entry_count);
            fail_tally++;
          end
        end
      end
      if (in_valid && !in_stall) owed_results.push_back(apply_lru_op(in_func, in_key));
    end
    owed_count = owed_results.size();
  end

endmodule

// ===== dv/lru_replacement_tracker_tb.sv =====
// Top of the lru_replacement_tracker testbench: clock, reset, input words,
// random output stalls and the verdict. Checking is done by
// lru_replacement_tracker_checker; types come from lrut_pkg.
`timescale 1ns / 100ps

module lru_replacement_tracker_tb;

  localparam int FUNC_W   = lrut_pkg::FUNC_W;
  localparam int KEY_W    = lrut_pkg::KEY_W;
  localparam int STAT_W   = lrut_pkg::STAT_W;
  localparam int CNT_W    = lrut_pkg::CNT_W;
  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 16;
  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1825;
  localparam int PHASE_WORDS  = 150;
  localparam int POOL_SIZE    = 20;
  // longest quiet stretch: a long input gap, a full-list operation and a long output stall
  localparam int IDLE_LIMIT   = 2000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func;
  logic [KEY_W-1:0]     in_key;
  logic                 out_valid;
  logic                 out_stall;
  logic [STAT_W-1:0]    out_status;
  logic [KEY_W-1:0]     out_victim_key;
  logic [CNT_W-1:0]     out_entry_count;

  int                   mismatch_count;
  int                   results_owed;
  int                   idle_cycles = 0;
  int                   stall_left = 0;
  bit                   steady = 1'b0;
  logic [KEY_W-1:0]     key_pool[POOL_SIZE];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  lru_replacement_tracker #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_victim_key (out_victim_key),
    .out_entry_count(out_entry_count)
  );

  lru_replacement_tracker_checker #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) lru_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_victim_key (out_victim_key),
    .out_entry_count(out_entry_count),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Returns at the rising edge where the word is taken.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_func <= FUNC_W'($urandom);
      in_key <= KEY_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_key <= k;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic random_word(input bit filling);
    int               r;
    logic [FUNC_W-1:0] f;
    logic [KEY_W-1:0]  k;
    r = $urandom_range(0, 99);
    if (r < 4) f = FN_UNUSED;
    else if (r < (filling ? 70 : 35)) f = lrut_pkg::FN_INSERT;
    else if (r < (filling ? 85 : 68)) f = lrut_pkg::FN_VICTIM;
    else f = lrut_pkg::FN_ERASE;
    // keys mostly from a small pool so hits, touches and the full case come up
    if ($urandom_range(0, 9) == 0) k = KEY_W'($urandom);
    else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    send_word(f, k);
  endtask

  initial begin
    int n;
    bit filling;
    filling = 1'b0;
    in_valid = 1'b0;
    in_func = lrut_pkg::FN_INSERT;
    in_key = '0;
    out_stall = 1'b0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(lrut_pkg::FN_VICTIM, 16'h0000);   // victim on empty
    send_word(FN_UNUSED, 16'hFFFF);
    send_word(lrut_pkg::FN_INSERT, 16'h0000);
    send_word(lrut_pkg::FN_INSERT, 16'hFFFF);
    send_word(lrut_pkg::FN_INSERT, 16'hAAAA);
    send_word(lrut_pkg::FN_INSERT, 16'h5555);
    send_word(lrut_pkg::FN_INSERT, 16'h0000);   // touch
    send_word(lrut_pkg::FN_ERASE,  16'hAAAA);   // erase from the middle
    send_word(lrut_pkg::FN_ERASE,  16'h1234);   // not found
    for (n = 0; n < ENTRIES - 3; n++) begin
      send_word(lrut_pkg::FN_INSERT, KEY_W'(16'h0100 + n));
    end
    send_word(lrut_pkg::FN_INSERT, 16'hBEEF);   // new key while full
    send_word(lrut_pkg::FN_INSERT, 16'hFFFF);   // touch while full
    send_word(lrut_pkg::FN_VICTIM, 16'h0000);

    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) begin
        filling = !filling;
        steady = ($urandom_range(0, 3) == 0);
        if (filling) begin
          foreach (key_pool[j]) key_pool[j] = KEY_W'($urandom);
        end
      end
      random_word(filling);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
